FILE: src/dtci_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dtci_pkg - shared types and constants for the displaced track cone isolation
// eta/phi arithmetic helpers, queue entry layout and back-end state encoding
// -----------------------------------------------------------------------------
package dtci_pkg;

	// field widths
	localparam int ETA_W   = 13;
	localparam int PHI_W   = 13;
	localparam int Z_W     = 15;
	localparam int DXY_W   = 14;
	localparam int PT_W    = 16;
	localparam int CONE_W  = 22;
	localparam int DIFF_W  = 14;   // eta/phi difference
	localparam int SQ_W    = 27;   // one squared difference
	localparam int DR_W    = 28;   // sum of two squares
	localparam int PDR_W   = 13;   // partner distance, below MIN_DR_SQ on a match
	localparam int RATIO_W = 16;

	// stream packing
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	// divider
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 5;

	// queue
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [DIFF_W-1:0] PI_FIX     = 14'sd3217;
	localparam logic signed [DIFF_W-1:0] TWO_PI_FIX = 14'sd6434;
	localparam logic [CONE_W-1:0]        CONE_RESET = 22'd94372;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIMARY_ETA    = 3'd0,
		REG_PRIMARY_PHI    = 3'd1,
		REG_PRIMARY_PT     = 3'd2,
		REG_PARTNER_ETA    = 3'd3,
		REG_PARTNER_PHI    = 3'd4,
		REG_PARTNER_ENABLE = 3'd5,
		REG_VERTEX_Z       = 3'd6,
		REG_CONE_RADIUS_SQ = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [ETA_W-1:0]  primary_eta;
		logic [PHI_W-1:0]  primary_phi;
		logic [ETA_W-1:0]  partner_eta;
		logic [PHI_W-1:0]  partner_phi;
		logic              partner_enable;
		logic [Z_W-1:0]    vertex_z;
		logic [CONE_W-1:0] cone_radius_sq;
	} geom_cfg_t;

	// one classified track, front to back
	typedef struct packed {
		logic             counted;
		logic             match;
		logic [PDR_W-1:0] pdr;
		logic [PT_W-1:0]  pt;
		logic             last;
	} trk_entry_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_PREP,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// signed difference of two 13-bit angles, wrapped once by 2*pi
	function automatic logic signed [DIFF_W-1:0] phi_delta(
		input logic [PHI_W-1:0] a,
		input logic [PHI_W-1:0] b
	);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[PHI_W-1], a}) - $signed({b[PHI_W-1], b});
		if (d > PI_FIX) begin
			d = d - TWO_PI_FIX;
		end else if (d < -PI_FIX) begin
			d = d + TWO_PI_FIX;
		end
		return d;
	endfunction

	function automatic logic signed [DIFF_W-1:0] eta_delta(
		input logic [ETA_W-1:0] a,
		input logic [ETA_W-1:0] b
	);
		return $signed({a[ETA_W-1], a}) - $signed({b[ETA_W-1], b});
	endfunction

endpackage

FILE: src/dtci_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dtci_fifo - short queue of classified tracks
// decouples the classifying front from the accumulating back
// -----------------------------------------------------------------------------
module dtci_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dtci_pkg::trk_entry_t din,
	output logic                 full,
	input  logic                 pop,
	output dtci_pkg::trk_entry_t dout,
	output logic                 empty
);
	import dtci_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	trk_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

endmodule

FILE: src/dtci_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dtci_front - track classification pipeline
// stage 1 forms eta/phi/z differences, stage 2 squares, then the cone tests
// -----------------------------------------------------------------------------
module dtci_front #(
	parameter int MIN_DR_SQ = 105,
	parameter int MAX_DZ    = 128,
	parameter int MAX_DXY   = 205
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dtci_pkg::S_DATA_W-1:0]       s_tdata,
	input  logic                                s_tlast,
	input  dtci_pkg::geom_cfg_t                 cfg,
	input  logic                                queue_full,
	output logic                                push,
	output dtci_pkg::trk_entry_t                entry
);
	import dtci_pkg::*;

	logic [ETA_W-1:0] trk_eta;
	logic [PHI_W-1:0] trk_phi;
	logic [Z_W-1:0]   trk_z;
	logic [DXY_W-1:0] trk_dxy;
	logic [PT_W-1:0]  trk_pt;

	logic signed [Z_W:0]  dz;
	logic [Z_W:0]         dz_abs;
	logic                 near;

	logic adv1;
	logic adv2;

	logic                     valid_s1;
	logic signed [DIFF_W-1:0] de_pri_s1;
	logic signed [DIFF_W-1:0] dp_pri_s1;
	logic signed [DIFF_W-1:0] de_par_s1;
	logic signed [DIFF_W-1:0] dp_par_s1;
	logic                     near_s1;
	logic [PT_W-1:0]          pt_s1;
	logic                     last_s1;

	logic signed [2*DIFF_W-1:0] p_de_pri;
	logic signed [2*DIFF_W-1:0] p_dp_pri;
	logic signed [2*DIFF_W-1:0] p_de_par;
	logic signed [2*DIFF_W-1:0] p_dp_par;

	logic              valid_s2;
	logic [SQ_W-1:0]   sq_de_pri_s2;
	logic [SQ_W-1:0]   sq_dp_pri_s2;
	logic [SQ_W-1:0]   sq_de_par_s2;
	logic [SQ_W-1:0]   sq_dp_par_s2;
	logic              near_s2;
	logic [PT_W-1:0]   pt_s2;
	logic              last_s2;

	logic [DR_W-1:0] dr_pri;
	logic [DR_W-1:0] dr_par;

	assign trk_eta = s_tdata[12:0];
	assign trk_phi = s_tdata[25:13];
	assign trk_z   = s_tdata[40:26];
	assign trk_dxy = s_tdata[54:41];
	assign trk_pt  = s_tdata[70:55];

	assign adv2     = !valid_s2 || !queue_full;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;
	assign push     = valid_s2 && !queue_full;

	// z window and impact limit
	always_comb begin
		dz     = $signed({trk_z[Z_W-1], trk_z}) - $signed({cfg.vertex_z[Z_W-1], cfg.vertex_z});
		dz_abs = dz[Z_W] ? (Z_W+1)'(-dz) : dz;
		near   = (dz_abs <= (Z_W+1)'(MAX_DZ)) &&
			($signed(trk_dxy) <= $signed(DXY_W'(MAX_DXY)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			de_pri_s1 <= eta_delta(cfg.primary_eta, trk_eta);
			dp_pri_s1 <= phi_delta(cfg.primary_phi, trk_phi);
			de_par_s1 <= eta_delta(cfg.partner_eta, trk_eta);
			dp_par_s1 <= phi_delta(cfg.partner_phi, trk_phi);
			near_s1   <= near;
			pt_s1     <= trk_pt;
			last_s1   <= s_tlast;
		end
	end

	assign p_de_pri = de_pri_s1 * de_pri_s1;
	assign p_dp_pri = dp_pri_s1 * dp_pri_s1;
	assign p_de_par = de_par_s1 * de_par_s1;
	assign p_dp_par = dp_par_s1 * dp_par_s1;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			sq_de_pri_s2 <= p_de_pri[SQ_W-1:0];
			sq_dp_pri_s2 <= p_dp_pri[SQ_W-1:0];
			sq_de_par_s2 <= p_de_par[SQ_W-1:0];
			sq_dp_par_s2 <= p_dp_par[SQ_W-1:0];
			near_s2      <= near_s1;
			pt_s2        <= pt_s1;
			last_s2      <= last_s1;
		end
	end

	// cone ring around the primary, tight match to the partner
	always_comb begin
		dr_pri = DR_W'(sq_de_pri_s2) + DR_W'(sq_dp_pri_s2);
		dr_par = DR_W'(sq_de_par_s2) + DR_W'(sq_dp_par_s2);
		entry.counted = near_s2 &&
			(dr_pri <= DR_W'(cfg.cone_radius_sq)) &&
			(dr_pri >= DR_W'(MIN_DR_SQ));
		entry.match = cfg.partner_enable && (dr_par < DR_W'(MIN_DR_SQ));
		entry.pdr   = dr_par[PDR_W-1:0];
		entry.pt    = pt_s2;
		entry.last  = last_s2;
	end

endmodule

FILE: src/dtci_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dtci_back - pt accumulation, partner removal and ratio division
// one queue entry per cycle in BK_RUN; a restoring divider closes a pass
// -----------------------------------------------------------------------------
module dtci_back #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	output logic                                pop,
	input  dtci_pkg::trk_entry_t                entry,
	input  logic [dtci_pkg::PT_W-1:0]           primary_pt,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dtci_pkg::RATIO_W-1:0]        iso_ratio,
	output logic                                ratio_saturated,
	output logic                                zero_divisor
);
	import dtci_pkg::*;

	localparam int CMP_W = (SUM_WIDTH > 24) ? SUM_WIDTH : 24;

	back_state_t state_q;
	back_state_t state_d;

	logic load_div;
	logic step_div;
	logic emit;

	// pass state
	logic [SUM_WIDTH-1:0] sum_q;
	logic                 ovf_q;
	logic [PDR_W-1:0]     best_q;
	logic [PT_W-1:0]      ppt_q;
	logic [SUM_WIDTH:0]   sum_ext;

	// divider
	logic [PT_W-1:0]      rem_q;
	logic [RATIO_W-1:0]   quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 big_q;
	logic                 zdiv_q;
	logic                 dovf_q;
	logic [SUM_WIDTH-1:0] diff;
	logic                 big;
	logic [PT_W:0]        trial;
	logic                 ge;

	// output register
	logic               m_valid_q;
	logic [RATIO_W-1:0] ratio_q;
	logic               sat_q;
	logic               zd_q;

	assign sum_ext = {1'b0, sum_q} + (SUM_WIDTH+1)'(entry.pt);

	always_comb begin
		diff  = (sum_q >= SUM_WIDTH'(ppt_q)) ? sum_q - SUM_WIDTH'(ppt_q) : '0;
		big   = (CMP_W'(diff) >= CMP_W'({primary_pt, 8'h00}));
		trial = {rem_q, quo_q[RATIO_W-1]};
		ge    = (trial >= {1'b0, primary_pt});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (!empty && entry.last) begin
					state_d = BK_PREP;
				end
			end
			BK_PREP: begin
				if ((primary_pt == '0) || big) begin
					state_d = BK_DONE;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		pop      = (state_q == BK_RUN) && !empty;
		load_div = (state_q == BK_PREP);
		step_div = (state_q == BK_DIV);
		emit     = (state_q == BK_DONE) && (!m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_RUN;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			best_q    <= '1;
			ppt_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && entry.counted) begin
				if (sum_ext[SUM_WIDTH]) begin
					sum_q <= '1;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_WIDTH-1:0];
				end
				if (entry.match && (entry.pdr < best_q)) begin
					best_q <= entry.pdr;
					ppt_q  <= entry.pt;
				end
			end
			if (load_div) begin
				sum_q  <= '0;
				ovf_q  <= 1'b0;
				best_q <= '1;
				ppt_q  <= '0;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (step_div) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in from the bottom while the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (load_div) begin
			rem_q  <= PT_W'(diff >> 8);
			quo_q  <= {diff[7:0], 8'h00};
			zdiv_q <= (primary_pt == '0);
			big_q  <= (primary_pt != '0) && big;
			dovf_q <= ovf_q;
		end else if (step_div) begin
			rem_q <= ge ? PT_W'(trial - {1'b0, primary_pt}) : trial[PT_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
		if (emit) begin
			ratio_q <= (zdiv_q || big_q) ? '1 : quo_q;
			sat_q   <= dovf_q || big_q;
			zd_q    <= zdiv_q;
		end
	end

	assign m_tvalid        = m_valid_q;
	assign iso_ratio       = ratio_q;
	assign ratio_saturated = sat_q;
	assign zero_divisor    = zd_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("entry taken from empty queue");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (cnt_q != '0))
		else $error("divider running with no steps left");

	a_zdiv_max: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && zd_q) |-> (ratio_q == '1))
		else $error("zero divisor without maximum ratio");

	a_pass_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_div |=> ((sum_q == '0) && !ovf_q && (best_q == '1)))
		else $error("pass state not cleared after last track");

endmodule

FILE: src/displaced_track_cone_isolation_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// displaced_track_cone_isolation_top - muon cone isolation over a track stream
// sums pt of tracks in the cone ring around the primary muon, removes the
// track matched to the partner muon and divides by the primary pt
// -----------------------------------------------------------------------------
//
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+-----------------------------------------
// s_        | in  | s_tvalid/s_tready  | s_tdata tracks, s_tlast last track
// m_        | out | m_tvalid/m_tready  | m_tdata ratio, m_tuser flags
// cfg_      | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// the front takes one track per cycle while the queue has room; its two
// pipeline stages feed a four-entry queue, and the back takes one entry per
// cycle from it in the run state; a pass ends in prep, 16 divider steps (the
// 16-bit restoring divider) and done, or prep and done alone when the divisor
// is zero or the quotient overflows; tracks keep filling the queue meanwhile
// reset clears the pipeline, queue, pass sums and output; config returns to
// its reset values and writes are always taken (cfg_ready is held high)
// a stalled m_ side backs up through the back, the queue and then s_tready
//
module displaced_track_cone_isolation_top #(
	parameter int MIN_DR_SQ = 105,
	parameter int MAX_DZ    = 128,
	parameter int MAX_DXY   = 205,
	parameter int SUM_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// track stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// track_eta[12:0], track_phi[25:13], track_z[40:26], track_dxy[54:41],
	// track_pt[70:55], zero pad[71]
	input  logic [dtci_pkg::S_DATA_W-1:0]       s_tdata,
	input  logic                                s_tlast,     // last_track
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dtci_pkg::M_DATA_W-1:0]       m_tdata,     // iso_ratio[15:0]
	// ratio_saturated[0], zero_divisor[1]
	output logic [dtci_pkg::M_USER_W-1:0]       m_tuser,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtci_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtci_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dtci_pkg::*;

	// configuration registers
	geom_cfg_t       geom_q;
	logic [PT_W-1:0] primary_pt_q;

	// front to queue
	logic       push;
	trk_entry_t push_entry;
	logic       queue_full;

	// queue to back
	logic       pop;
	trk_entry_t pop_entry;
	logic       queue_empty;

	logic ratio_saturated;
	logic zero_divisor;

	assign cfg_ready = 1'b1;

	// config transfer; the user must keep the block idle for it (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.primary_eta    <= '0;
			geom_q.primary_phi    <= '0;
			geom_q.partner_eta    <= '0;
			geom_q.partner_phi    <= '0;
			geom_q.partner_enable <= 1'b0;
			geom_q.vertex_z       <= '0;
			geom_q.cone_radius_sq <= CONE_RESET;
			primary_pt_q          <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRIMARY_ETA:    geom_q.primary_eta    <= cfg_data[ETA_W-1:0];
				REG_PRIMARY_PHI:    geom_q.primary_phi    <= cfg_data[PHI_W-1:0];
				REG_PRIMARY_PT:     primary_pt_q          <= cfg_data[PT_W-1:0];
				REG_PARTNER_ETA:    geom_q.partner_eta    <= cfg_data[ETA_W-1:0];
				REG_PARTNER_PHI:    geom_q.partner_phi    <= cfg_data[PHI_W-1:0];
				REG_PARTNER_ENABLE: geom_q.partner_enable <= cfg_data[0];
				REG_VERTEX_Z:       geom_q.vertex_z       <= cfg_data[Z_W-1:0];
				REG_CONE_RADIUS_SQ: geom_q.cone_radius_sq <= cfg_data[CONE_W-1:0];
				default: ;
			endcase
		end
	end

	// classification: distances, cone ring, z window, impact limit
	dtci_front #(
		.MIN_DR_SQ (MIN_DR_SQ),
		.MAX_DZ    (MAX_DZ),
		.MAX_DXY   (MAX_DXY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg        (geom_q),
		.queue_full (queue_full),
		.push       (push),
		.entry      (push_entry)
	);

	dtci_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.full   (queue_full),
		.pop    (pop),
		.dout   (pop_entry),
		.empty  (queue_empty)
	);

	// accumulation, partner removal and division
	dtci_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (queue_empty),
		.pop             (pop),
		.entry           (pop_entry),
		.primary_pt      (primary_pt_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.iso_ratio       (m_tdata),
		.ratio_saturated (ratio_saturated),
		.zero_divisor    (zero_divisor)
	);

	assign m_tuser = {zero_divisor, ratio_saturated};

endmodule
